### src/dfr_pkg.sv
// dfr_pkg: shared types, codes and constants of the sequenced block deframer
// holds parse phase codes, event codes, the result record and the crc-32 byte update
// no dependencies
package dfr_pkg;

    // widths of the result fields
    localparam int OFF_W   = 13;
    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 3;
    localparam int FAIL_W  = 16;
    localparam int PHASE_W = 3;

    // parse phase codes
    localparam logic [PHASE_W-1:0] PH_SEQ = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEN = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PAY = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CRC = 3'd3;
    localparam logic [PHASE_W-1:0] PH_XOR = 3'd4;
    localparam logic [PHASE_W-1:0] PH_END = 3'd5;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_ACCEPTED = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DUP      = 3'd2;
    localparam logic [EVENT_W-1:0] EV_ABORT    = 3'd3;
    localparam logic [EVENT_W-1:0] EV_CRC_BAD  = 3'd4;
    localparam logic [EVENT_W-1:0] EV_XOR_BAD  = 3'd5;
    localparam logic [EVENT_W-1:0] EV_END      = 3'd6;
    localparam logic [EVENT_W-1:0] EV_END_BAD  = 3'd7;

    // crc and buffer constants
    localparam logic [31:0]      CRC_POLY        = 32'hEDB88320;
    localparam logic [31:0]      CRC_INIT        = 32'hFFFFFFFF;
    localparam logic [OFF_W-1:0] FLUSH_THRESHOLD = 13'd4096;
    localparam logic [FAIL_W-1:0] FAIL_MAX       = 16'hFFFF;

    // default depth of the result queue
    localparam int QUEUE_DEPTH_DEF = 4;

    // one result record
    typedef struct packed {
        logic               write_enable;
        logic [OFF_W-1:0]   write_offset;
        logic [BYTE_W-1:0]  write_data;
        logic [EVENT_W-1:0] event_code;
        logic [OFF_W-1:0]   committed_count;
        logic               flush_request;
        logic [FAIL_W-1:0]  error_count;
    } result_t;

    // reflected crc-32 update over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### src/dfr_parser.sv
// dfr_parser: front part of the deframer, parses one byte per transfer
// keeps all frame state and pushes one result record per byte; uses dfr_pkg
module dfr_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_enable,
    input  logic              cfg_write_data,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output dfr_pkg::result_t  result
);
    import dfr_pkg::*;

    logic               verify_crc_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]         exp_seq_reg, exp_seq_next;
    logic [7:0]         xor_reg, xor_next;
    logic [7:0]         blk_len_reg, blk_len_next;
    logic [7:0]         pay_cnt_reg, pay_cnt_next;
    logic [31:0]        crc_reg, crc_next;
    logic [31:0]        rx_crc_reg, rx_crc_next;
    logic [1:0]         crc_cnt_reg, crc_cnt_next;
    logic [OFF_W-1:0]   fill_reg, fill_next;
    logic [OFF_W-1:0]   woff_reg, woff_next;
    logic [FAIL_W-1:0]  fail_reg, fail_next;

    logic [7:0]         pay_cnt_inc;
    logic [1:0]         crc_cnt_inc;
    logic [31:0]        rx_crc_shift;
    logic [FAIL_W-1:0]  fail_bump;
    logic               flushed;
    logic [OFF_W-1:0]   flushed_count;
    logic [OFF_W-1:0]   new_fill;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            verify_crc_reg <= 1'b0;
        else if (cfg_write_enable)
            verify_crc_reg <= cfg_write_data;
    end

    assign pay_cnt_inc  = pay_cnt_reg + 8'd1;
    assign crc_cnt_inc  = crc_cnt_reg + 2'd1;
    assign rx_crc_shift = {rx_crc_reg[23:0], rx_byte};
    assign fail_bump    = (fail_reg != FAIL_MAX) ? fail_reg + 16'd1 : fail_reg;
    assign new_fill     = woff_reg;

    // parse step
    always_comb
    begin
        phase_next    = phase_reg;
        exp_seq_next  = exp_seq_reg;
        xor_next      = xor_reg;
        blk_len_next  = blk_len_reg;
        pay_cnt_next  = pay_cnt_reg;
        crc_next      = crc_reg;
        rx_crc_next   = rx_crc_reg;
        crc_cnt_next  = crc_cnt_reg;
        fill_next     = fill_reg;
        woff_next     = woff_reg;
        fail_next     = fail_reg;
        flushed       = 1'b0;
        flushed_count = '0;
        result        = '0;

        case (phase_reg)
            PH_LEN:
            begin
                blk_len_next = rx_byte;
                if (rx_byte == 8'd0)
                    phase_next = PH_END;
                else
                begin
                    xor_next     = xor_reg ^ rx_byte;
                    pay_cnt_next = 8'd0;
                    woff_next    = fill_reg;
                    crc_next     = CRC_INIT;
                    phase_next   = PH_PAY;
                end
            end
            PH_PAY:
            begin
                xor_next            = xor_reg ^ rx_byte;
                crc_next            = crc_byte(crc_reg, rx_byte);
                result.write_enable = 1'b1;
                result.write_offset = woff_reg;
                result.write_data   = rx_byte;
                woff_next           = woff_reg + 13'd1;
                pay_cnt_next        = pay_cnt_inc;
                if (pay_cnt_inc == blk_len_reg)
                begin
                    if (verify_crc_reg)
                    begin
                        rx_crc_next  = 32'd0;
                        crc_cnt_next = 2'd0;
                        phase_next   = PH_CRC;
                    end
                    else
                        phase_next = PH_XOR;
                end
            end
            PH_CRC:
            begin
                xor_next     = xor_reg ^ rx_byte;
                rx_crc_next  = rx_crc_shift;
                crc_cnt_next = crc_cnt_inc;
                if (crc_cnt_inc == 2'd0)
                begin
                    if (crc_reg != rx_crc_shift)
                    begin
                        fail_next         = fail_bump;
                        result.event_code = EV_CRC_BAD;
                        phase_next        = PH_SEQ;
                    end
                    else
                        phase_next = PH_XOR;
                end
            end
            PH_XOR:
            begin
                phase_next = PH_SEQ;
                if (rx_byte != xor_reg)
                    result.event_code = EV_XOR_BAD;
                else
                begin
                    fill_next = new_fill;
                    if (new_fill >= FLUSH_THRESHOLD)
                    begin
                        flushed       = 1'b1;
                        flushed_count = new_fill;
                        fill_next     = '0;
                    end
                    exp_seq_next      = exp_seq_reg + 8'd1;
                    fail_next         = '0;
                    result.event_code = EV_ACCEPTED;
                end
            end
            PH_END:
            begin
                phase_next = PH_SEQ;
                if (rx_byte != xor_reg)
                begin
                    fail_next         = fail_bump;
                    result.event_code = EV_END_BAD;
                end
                else
                begin
                    if (fill_reg != '0)
                    begin
                        flushed       = 1'b1;
                        flushed_count = fill_reg;
                        fill_next     = '0;
                    end
                    result.event_code = EV_END;
                end
            end
            default:
            begin
                // sequence byte; unused codes behave the same
                phase_next = PH_SEQ;
                if (rx_byte != exp_seq_reg)
                begin
                    if (rx_byte + 8'd1 == exp_seq_reg)
                        result.event_code = EV_DUP;
                    else
                        result.event_code = EV_ABORT;
                end
                else
                begin
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = PH_LEN;
                end
            end
        endcase

        result.flush_request   = flushed;
        result.committed_count = flushed ? flushed_count : fill_next;
        result.error_count     = fail_next;
    end

    // control state, updated per accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SEQ;
            exp_seq_reg <= '0;
            xor_reg     <= '0;
            blk_len_reg <= '0;
            pay_cnt_reg <= '0;
            crc_reg     <= CRC_INIT;
            rx_crc_reg  <= '0;
            crc_cnt_reg <= '0;
            fill_reg    <= '0;
            woff_reg    <= '0;
            fail_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            exp_seq_reg <= exp_seq_next;
            xor_reg     <= xor_next;
            blk_len_reg <= blk_len_next;
            pay_cnt_reg <= pay_cnt_next;
            crc_reg     <= crc_next;
            rx_crc_reg  <= rx_crc_next;
            crc_cnt_reg <= crc_cnt_next;
            fill_reg    <= fill_next;
            woff_reg    <= woff_next;
            fail_reg    <= fail_next;
        end
    end

    // a partly gathered crc only exists inside the crc phase
    assert property (@(posedge clk) disable iff (!rst_n)
        crc_cnt_reg != 2'd0 |-> phase_reg == PH_CRC)
        else $error("crc byte counter busy outside crc phase");

    // payload writes come only from the payload phase
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.write_enable |-> phase_reg == PH_PAY)
        else $error("payload write outside payload phase");

    // flush only on an accepted block or a good end marker
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.flush_request |->
            (result.event_code == EV_ACCEPTED || result.event_code == EV_END))
        else $error("flush request without accept or end");

endmodule

### src/dfr_queue.sv
// dfr_queue: back part of the deframer, a short queue of result records
// decouples the parser from the output stall; uses dfr_pkg
module dfr_queue #(
    parameter int DEPTH = dfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dfr_pkg::result_t  push_data,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output dfr_pkg::result_t  head
);
    import dfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    result_t           mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    // storage write
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // occupancy never exceeds the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue overflow");

    // a lone push grows the queue by exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count lost a push");

endmodule

### src/sequenced_block_deframer_core.sv
// sequenced_block_deframer_core: top level of the sequenced block deframer
// connects the byte parser (dfr_parser) to the result queue (dfr_queue); uses dfr_pkg
//
// Takes one received byte per input transfer and returns exactly one result per byte:
// a payload write (offset and data), a frame event, the committed byte count, a flush
// request and the consecutive error count. Frames are sequence, length, payload, an
// optional big-endian CRC-32 (verify_crc = 1) and an XOR byte; length zero ends the
// transfer. The parser handles one byte per clock while in_stall is low, its CRC-32 byte
// update being combinational, so a byte can be taken every cycle unless the queue is full.
// Each result is written into a queue of QUEUE_DEPTH entries and shown on the output once
// it reaches the queue head; in_stall rises only when that queue is full. Write verify_crc
// only when no results are pending.
module sequenced_block_deframer_core #(
    parameter int QUEUE_DEPTH = dfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        write_enable,
    output logic [12:0] write_offset,
    output logic [7:0]  write_data,
    output logic [2:0]  event_code,
    output logic [12:0] committed_count,
    output logic        flush_request,
    output logic [15:0] error_count
);
    import dfr_pkg::*;

    logic    accept;
    logic    pop;
    logic    full;
    result_t parsed;
    result_t head;

    // input transfer and output transfer
    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign pop      = out_valid && !out_stall;

    dfr_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .accept           (accept),
        .rx_byte          (rx_byte),
        .result           (parsed)
    );

    dfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (parsed),
        .pop       (pop),
        .full      (full),
        .not_empty (out_valid),
        .head      (head)
    );

    // result fields
    assign write_enable    = head.write_enable;
    assign write_offset    = head.write_offset;
    assign write_data      = head.write_data;
    assign event_code      = head.event_code;
    assign committed_count = head.committed_count;
    assign flush_request   = head.flush_request;
    assign error_count     = head.error_count;

endmodule
